/* rtl/euler_to_quaternion_macros.svh */
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define E2Q_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("euler_to_quaternion: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("euler_to_quaternion: assertion failed");

`endif

/* rtl/e2q_pkg.sv */
package e2q_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COMPONENT_BITS = 16;

  // Upper angle bits above the 1024 units that divide one turn evenly.
  localparam int HI_BITS = ANGLE_BITS - 10;
  localparam logic [5:0] HI_WRAP = 6'((64'd1 << HI_BITS) % 64'd45);

  localparam int LANE_STAGES  = 13;
  localparam int MERGE_STAGES = 4;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [15:0] QUARTER_TURN = 16'd11520;
  localparam logic [15:0] EIGHTH_TURN  = 16'd5760;
  localparam logic [17:0] RAD_PER_UNIT = 18'd146409;

  // Horner divisors split into a power of two and an odd factor.
  localparam int STEPS = 3;
  localparam int SIN_SHIFT [STEPS] = '{1, 2, 1};
  localparam int SIN_ODD   [STEPS] = '{21, 5, 3};
  localparam int COS_SHIFT [STEPS] = '{3, 1, 2};
  localparam int COS_ODD   [STEPS] = '{7, 15, 3};

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sincos_t;

endpackage

/* rtl/euler_to_quaternion.sv */
// An output word shows once its input word has passed through every pipeline stage, later if stalled.
// Throughput: one word per cycle while the output word is not held back; each of the 17 pipeline stages advances
// whenever any stage at or after it is empty or the output word is taken.
// Reset clears only the stage valid bits, so no output word is shown after reset
// until a new input word has passed through the whole pipeline.
module euler_to_quaternion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  e2q_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output e2q_pkg::out_word_t out_word_o
);

  localparam int P  = e2q_pkg::PIPE_STAGES;
  localparam int LS = e2q_pkg::LANE_STAGES;

  logic [P-1:0]     valid_d, valid_q, stage_en;
  e2q_pkg::sincos_t sc_x, sc_y, sc_z;

  for (genvar k = 0; k < P; k++) begin : g_en
    assign stage_en[k] = !(&valid_q[P-1:k]) || !out_stall_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < P; k++) begin
      if (stage_en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !stage_en[0];
  assign out_valid_o = valid_q[P-1];

  e2q_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (stage_en[LS-1:0]),
    .angle_i (in_word_i.angle_x),
    .sc_o    (sc_x)
  );

  e2q_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (stage_en[LS-1:0]),
    .angle_i (in_word_i.angle_y),
    .sc_o    (sc_y)
  );

  e2q_lane u_lane_z (
    .clk_i   (clk_i),
    .en_i    (stage_en[LS-1:0]),
    .angle_i (in_word_i.angle_z),
    .sc_o    (sc_z)
  );

  e2q_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (stage_en[P-1:LS]),
    .sc_x_i (sc_x),
    .sc_y_i (sc_y),
    .sc_z_i (sc_z),
    .word_o (out_word_o)
  );

endmodule

/* rtl/e2q_lane.sv */
module e2q_lane (
  input  logic                                  clk_i,
  input  logic [e2q_pkg::LANE_STAGES-1:0]       en_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_i,
  output e2q_pkg::sincos_t                      sc_o
);

  localparam int AB = e2q_pkg::ANGLE_BITS;

  logic [23:0]        hi_ext;
  logic [12:0]        chunk_sum_d, chunk_sum_q;
  logic               sign_q;
  logic [9:0]         low_q;

  logic [23:0]        quo_prod;
  logic [7:0]         quo;
  logic signed [15:0] rem_a;
  logic signed [7:0]  rem_b, rem_c, rem_d;
  logic [15:0]        phase_d, phase_q;

  logic [1:0]         quad;
  logic [15:0]        frac;
  logic [12:0]        fold_d, fold_q;
  logic               swap_d;

  logic [59:0]        sq;
  logic [29:0]        x_pipe  [3:10];
  logic [29:0]        x2_pipe [4:10];
  logic [2:0]         tag_pipe [2:11];

  logic [60:0]        prod_s_q [e2q_pkg::STEPS];
  logic [60:0]        prod_c_q [e2q_pkg::STEPS];
  logic [65:0]        dm_s_q   [e2q_pkg::STEPS];
  logic [65:0]        dm_c_q   [e2q_pkg::STEPS];
  logic [30:0]        p_s      [e2q_pkg::STEPS+1];
  logic [30:0]        p_c      [e2q_pkg::STEPS+1];

  logic [60:0]        fin_s_q, fin_c_q;
  logic [30:0]        s_val, c_val, s0, c0;
  logic signed [31:0] sp, cp;
  e2q_pkg::sincos_t   sc_d, sc_q;

  // Since 4096 is 1 modulo 45, the upper bits reduce by adding 12-bit chunks.
  assign hi_ext      = 24'(angle_i[AB-1:10]);
  assign chunk_sum_d = 13'(hi_ext[11:0]) + 13'(hi_ext[23:12]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      chunk_sum_q <= chunk_sum_d;
      sign_q      <= angle_i[AB-1];
      low_q       <= angle_i[9:0];
    end
  end

  always_comb begin
    quo_prod = 24'(chunk_sum_q) * 24'd1457;
    quo      = quo_prod[23:16];
    rem_a    = signed'(16'(chunk_sum_q)) - signed'(16'(quo) * 16'd45);
    rem_b    = (rem_a < 0) ? 8'(rem_a + 16'sd45) : 8'(rem_a);
    rem_c    = rem_b - (sign_q ? 8'(e2q_pkg::HI_WRAP) : 8'd0);
    rem_d    = (rem_c < 0) ? rem_c + 8'sd45 : rem_c;
    phase_d  = {rem_d[5:0], low_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    priority if (phase_q >= 16'd34560) begin
      quad = 2'd3;
      frac = phase_q - 16'd34560;
    end else if (phase_q >= 16'd23040) begin
      quad = 2'd2;
      frac = phase_q - 16'd23040;
    end else if (phase_q >= e2q_pkg::QUARTER_TURN) begin
      quad = 2'd1;
      frac = phase_q - e2q_pkg::QUARTER_TURN;
    end else begin
      quad = 2'd0;
      frac = phase_q;
    end
    if (frac <= e2q_pkg::EIGHTH_TURN) begin
      fold_d = frac[12:0];
      swap_d = 1'b0;
    end else begin
      fold_d = 13'(e2q_pkg::QUARTER_TURN - frac);
      swap_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      fold_q      <= fold_d;
      tag_pipe[2] <= {swap_d, quad};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      x_pipe[3]   <= 30'(31'(fold_q) * 31'(e2q_pkg::RAD_PER_UNIT));
      tag_pipe[3] <= tag_pipe[2];
    end
  end

  assign sq = 60'(x_pipe[3]) * 60'(x_pipe[3]);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      x_pipe[4]   <= x_pipe[3];
      x2_pipe[4]  <= sq[59:30];
      tag_pipe[4] <= tag_pipe[3];
    end
  end

  assign p_s[0] = e2q_pkg::Q30_ONE;
  assign p_c[0] = e2q_pkg::Q30_ONE;

  for (genvar j = 0; j < e2q_pkg::STEPS; j++) begin : g_step
    localparam int SA = 5 + 2 * j;
    localparam int SB = 6 + 2 * j;
    localparam logic [34:0] SIN_M = 35'((64'd1 << 35) / 64'(e2q_pkg::SIN_ODD[j]) + 64'd1);
    localparam logic [34:0] COS_M = 35'((64'd1 << 35) / 64'(e2q_pkg::COS_ODD[j]) + 64'd1);

    logic [30:0] n_s, n_c;

    assign n_s = prod_s_q[j][60:30] >> e2q_pkg::SIN_SHIFT[j];
    assign n_c = prod_c_q[j][60:30] >> e2q_pkg::COS_SHIFT[j];

    always_ff @(posedge clk_i) begin
      if (en_i[SA]) begin
        prod_s_q[j]  <= 61'(x2_pipe[SA-1]) * 61'(p_s[j]);
        prod_c_q[j]  <= 61'(x2_pipe[SA-1]) * 61'(p_c[j]);
        x_pipe[SA]   <= x_pipe[SA-1];
        x2_pipe[SA]  <= x2_pipe[SA-1];
        tag_pipe[SA] <= tag_pipe[SA-1];
      end
      if (en_i[SB]) begin
        dm_s_q[j]    <= 66'(n_s) * 66'(SIN_M);
        dm_c_q[j]    <= 66'(n_c) * 66'(COS_M);
        x_pipe[SB]   <= x_pipe[SA];
        x2_pipe[SB]  <= x2_pipe[SA];
        tag_pipe[SB] <= tag_pipe[SA];
      end
    end

    assign p_s[j+1] = e2q_pkg::Q30_ONE - 31'(dm_s_q[j] >> 35);
    assign p_c[j+1] = e2q_pkg::Q30_ONE - 31'(dm_c_q[j] >> 35);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[11]) begin
      fin_s_q      <= 61'(x_pipe[10]) * 61'(p_s[e2q_pkg::STEPS]);
      fin_c_q      <= 61'(x2_pipe[10]) * 61'(p_c[e2q_pkg::STEPS]);
      tag_pipe[11] <= tag_pipe[10];
    end
  end

  always_comb begin
    s_val = fin_s_q[60:30];
    c_val = e2q_pkg::Q30_ONE - 31'(fin_c_q[60:31]);
    s0    = tag_pipe[11][2] ? c_val : s_val;
    c0    = tag_pipe[11][2] ? s_val : c_val;
    sp    = signed'({1'b0, s0});
    cp    = signed'({1'b0, c0});
    unique case (tag_pipe[11][1:0])
      2'd0: begin
        sc_d.s = sp;
        sc_d.c = cp;
      end
      2'd1: begin
        sc_d.s = cp;
        sc_d.c = -sp;
      end
      2'd2: begin
        sc_d.s = -sp;
        sc_d.c = -cp;
      end
      default: begin
        sc_d.s = -cp;
        sc_d.c = sp;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[12]) begin
      sc_q <= sc_d;
    end
  end

  assign sc_o = sc_q;

endmodule

/* rtl/e2q_merge.sv */
module e2q_merge (
  input  logic                             clk_i,
  input  logic [e2q_pkg::MERGE_STAGES-1:0] en_i,
  input  e2q_pkg::sincos_t                 sc_x_i,
  input  e2q_pkg::sincos_t                 sc_y_i,
  input  e2q_pkg::sincos_t                 sc_z_i,
  output e2q_pkg::out_word_t               word_o
);

  localparam int CB     = e2q_pkg::COMPONENT_BITS;
  localparam int CSHIFT = 31 - CB;
  localparam logic [33:0] POS_LIMIT = 34'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic [61:0] HALF_LSB  = 62'd1 << 29;

  // Triple product t is pair TRI_PAIR[t] times sz when TRI_USE_S[t], else times cz.
  localparam int TRI_PAIR  [8] = '{0, 1, 2, 3, 3, 2, 0, 1};
  localparam int TRI_USE_S [8] = '{0, 1, 0, 1, 0, 1, 1, 0};

  function automatic logic [30:0] mag(input logic signed [31:0] v);
    return v[31] ? 31'(-v) : 31'(v);
  endfunction

  function automatic logic [CB-1:0] to_comp(input logic signed [32:0] v);
    logic        neg;
    logic [33:0] m, r, lim;
    neg = v[32];
    m   = neg ? 34'(-v) : 34'(v);
    if (CSHIFT > 0) begin
      r = (m + (34'd1 << (CSHIFT - 1))) >> CSHIFT;
    end else if (CSHIFT < 0) begin
      r = m << 1;
    end else begin
      r = m;
    end
    lim = neg ? POS_LIMIT + 34'd1 : POS_LIMIT;
    if (r > lim) begin
      r = lim;
    end
    return neg ? CB'(34'd0 - r) : CB'(r);
  endfunction

  logic signed [31:0] pa [4];
  logic signed [31:0] pb [4];
  logic [61:0]        pair_mag_q [4];
  logic               pair_neg_q [4];
  logic signed [31:0] cz_q, sz_q;

  logic [30:0]        pair_round [4];
  logic               pair_sign  [4];
  logic signed [31:0] third      [8];
  logic [61:0]        tri_mag_q  [8];
  logic               tri_neg_q  [8];

  logic [30:0]        tri_round  [8];
  logic signed [32:0] tri_val    [8];
  logic signed [32:0] sum_d      [4];
  logic signed [32:0] sum_q      [4];

  e2q_pkg::out_word_t word_q;

  always_comb begin
    pa[0] = sc_y_i.c;
    pb[0] = sc_x_i.c;
    pa[1] = sc_y_i.s;
    pb[1] = sc_x_i.s;
    pa[2] = sc_y_i.c;
    pb[2] = sc_x_i.s;
    pa[3] = sc_y_i.s;
    pb[3] = sc_x_i.c;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 4; i++) begin
        pair_mag_q[i] <= 62'(mag(pa[i])) * 62'(mag(pb[i]));
        pair_neg_q[i] <= pa[i][31] ^ pb[i][31];
      end
      cz_q <= sc_z_i.c;
      sz_q <= sc_z_i.s;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pair_round[i] = 31'((pair_mag_q[i] + HALF_LSB) >> 30);
      pair_sign[i]  = pair_neg_q[i] & (pair_round[i] != 31'd0);
    end
    for (int t = 0; t < 8; t++) begin
      third[t] = (TRI_USE_S[t] != 0) ? sz_q : cz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int t = 0; t < 8; t++) begin
        tri_mag_q[t] <= 62'(pair_round[TRI_PAIR[t]]) * 62'(mag(third[t]));
        tri_neg_q[t] <= pair_sign[TRI_PAIR[t]] ^ third[t][31];
      end
    end
  end

  always_comb begin
    for (int t = 0; t < 8; t++) begin
      tri_round[t] = 31'((tri_mag_q[t] + HALF_LSB) >> 30);
      tri_val[t]   = tri_neg_q[t] ? -signed'({2'b00, tri_round[t]})
                                  : signed'({2'b00, tri_round[t]});
    end
    sum_d[0] = tri_val[0] + tri_val[1];
    sum_d[1] = tri_val[2] + tri_val[3];
    sum_d[2] = tri_val[4] - tri_val[5];
    sum_d[3] = tri_val[6] - tri_val[7];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      word_q.quat_w <= signed'(to_comp(sum_q[0]));
      word_q.quat_x <= signed'(to_comp(sum_q[1]));
      word_q.quat_y <= signed'(to_comp(sum_q[2]));
      word_q.quat_z <= signed'(to_comp(sum_q[3]));
    end
  end

  assign word_o = word_q;

endmodule

/* rtl/e2q_checker.sv */
`include "euler_to_quaternion_macros.svh"

module e2q_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input e2q_pkg::out_word_t out_word_o
);

  // An empty output stage means the whole pipeline can move.
  `E2Q_ASSERT_IMPL(a_no_stall_when_drained, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // The input side only stalls when a finished word is held back.
  `E2Q_ASSERT_IMPL(a_stall_has_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  `E2Q_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

endmodule

bind euler_to_quaternion e2q_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
